// ----- rtl/rset_pkg.sv -----
package rset_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // request codes
   localparam logic [1:0] REQ_ARRIVE = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_PREV   = 2'd2;
   localparam logic [1:0] REQ_NEXT   = 2'd3;

   // datapath commands
   localparam int CMD_W = 4;
   localparam logic [CMD_W-1:0] CMD_NONE      = 4'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD      = 4'd1;
   localparam logic [CMD_W-1:0] CMD_SCAN_REQ  = 4'd2;
   localparam logic [CMD_W-1:0] CMD_SCAN_CUR  = 4'd3;
   localparam logic [CMD_W-1:0] CMD_STORE_OLD = 4'd4;
   localparam logic [CMD_W-1:0] CMD_STORE_NEW = 4'd5;
   localparam logic [CMD_W-1:0] CMD_SORT_LOAD = 4'd6;
   localparam logic [CMD_W-1:0] CMD_SORT_CMP  = 4'd7;
   localparam logic [CMD_W-1:0] CMD_SEL_SCAN  = 4'd8;
   localparam logic [CMD_W-1:0] CMD_SHIFT     = 4'd9;
   localparam logic [CMD_W-1:0] CMD_SEL_REM   = 4'd10;
   localparam logic [CMD_W-1:0] CMD_NAV       = 4'd11;
   localparam logic [CMD_W-1:0] CMD_OUT       = 4'd12;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] entry_uuid;
      logic [7:0]  entry_flags;
      logic [31:0] entry_time;
   } req_item_type;

   typedef struct packed {
      logic [31:0]      cur_uuid;
      logic [7:0]       cur_flags;
      logic [CNT_W-1:0] cur_pos;
      logic [CNT_W-1:0] entry_count;
      logic             has_current;
      logic             alert;
      logic             found;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0] id;
      logic [7:0]  flags;
      logic [31:0] tstamp;
      logic [31:0] seq;
   } entry_type;

   typedef struct packed {
      logic scan_hit;
      logic scan_end;
      logic sort_done;
      logic sort_move;
      logic shift_done;
      logic rem_reloc;
      logic cur_valid;
      logic out_free;
   } status_type;

   // a is newer than b: timestamps decide when both known and different
   function automatic logic is_newer(entry_type a, entry_type b);
      if (a.tstamp != 32'd0 && b.tstamp != 32'd0 && a.tstamp != b.tstamp) begin
         return a.tstamp > b.tstamp;
      end
      return a.seq > b.seq;
   endfunction

endpackage

// ----- rtl/rset_ctrl.sv -----
module rset_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [1:0]                   req_kind,
   output logic                         req_stall,
   input  rset_pkg::status_type         status,
   output logic [rset_pkg::CMD_W-1:0]   cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_FIND_A    = 4'd1;
   localparam logic [3:0] S_STORE_OLD = 4'd2;
   localparam logic [3:0] S_STORE_NEW = 4'd3;
   localparam logic [3:0] S_SORT_LOAD = 4'd4;
   localparam logic [3:0] S_SORT_CMP  = 4'd5;
   localparam logic [3:0] S_FIND_N    = 4'd6;
   localparam logic [3:0] S_SEL_N     = 4'd7;
   localparam logic [3:0] S_RELOC     = 4'd8;
   localparam logic [3:0] S_FIND_R    = 4'd9;
   localparam logic [3:0] S_SHIFT     = 4'd10;
   localparam logic [3:0] S_REM_SEL   = 4'd11;
   localparam logic [3:0] S_NAV       = 4'd12;
   localparam logic [3:0] S_OUT       = 4'd13;

   logic [3:0] state_ff, state_in;
   logic       fresh_ff, fresh_in;

   assign req_stall = (state_ff != S_IDLE);

   // next state and command
   always_comb begin
      state_in = state_ff;
      fresh_in = fresh_ff;
      cmd      = rset_pkg::CMD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd      = rset_pkg::CMD_LOAD;
               fresh_in = 1'b0;
               case (req_kind)
                  rset_pkg::REQ_ARRIVE: state_in = S_FIND_A;
                  rset_pkg::REQ_REMOVE: state_in = S_FIND_R;
                  default:              state_in = S_NAV;
               endcase
            end
         end
         S_FIND_A: begin
            cmd = rset_pkg::CMD_SCAN_REQ;
            if (status.scan_hit) begin
               state_in = S_STORE_OLD;
            end else if (status.scan_end) begin
               state_in = S_STORE_NEW;
            end
         end
         S_STORE_OLD: begin
            cmd      = rset_pkg::CMD_STORE_OLD;
            state_in = S_SORT_LOAD;
         end
         S_STORE_NEW: begin
            cmd      = rset_pkg::CMD_STORE_NEW;
            fresh_in = 1'b1;
            state_in = S_SORT_LOAD;
         end
         S_SORT_LOAD: begin
            cmd = rset_pkg::CMD_SORT_LOAD;
            if (!status.sort_done) begin
               state_in = S_SORT_CMP;
            end else if (fresh_ff) begin
               state_in = S_FIND_N;
            end else if (status.cur_valid) begin
               state_in = S_RELOC;
            end else begin
               state_in = S_OUT;
            end
         end
         S_SORT_CMP: begin
            cmd = rset_pkg::CMD_SORT_CMP;
            if (!status.sort_move) begin
               state_in = S_SORT_LOAD;
            end
         end
         S_FIND_N: begin
            cmd = rset_pkg::CMD_SCAN_REQ;
            if (status.scan_hit || status.scan_end) begin
               state_in = S_SEL_N;
            end
         end
         S_SEL_N: begin
            cmd      = rset_pkg::CMD_SEL_SCAN;
            state_in = S_OUT;
         end
         S_RELOC: begin
            cmd = rset_pkg::CMD_SCAN_CUR;
            if (status.scan_hit || status.scan_end) begin
               state_in = S_OUT;
            end
         end
         S_FIND_R: begin
            cmd = rset_pkg::CMD_SCAN_REQ;
            if (status.scan_hit) begin
               state_in = S_SHIFT;
            end else if (status.scan_end) begin
               state_in = S_OUT;
            end
         end
         S_SHIFT: begin
            cmd = rset_pkg::CMD_SHIFT;
            if (status.shift_done) begin
               state_in = S_REM_SEL;
            end
         end
         S_REM_SEL: begin
            cmd      = rset_pkg::CMD_SEL_REM;
            state_in = status.rem_reloc ? S_RELOC : S_OUT;
         end
         S_NAV: begin
            cmd      = rset_pkg::CMD_NAV;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd      = rset_pkg::CMD_OUT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fresh_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fresh_ff <= fresh_in;
      end
   end

endmodule

// ----- rtl/rset_dp.sv -----
module rset_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [rset_pkg::CMD_W-1:0]   cmd,
   input  rset_pkg::req_item_type       req_data,
   output rset_pkg::status_type         status,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output rset_pkg::rsp_item_type       rsp_data
);

   localparam int CW = rset_pkg::CNT_W;
   localparam int IW = rset_pkg::IDX_W;
   localparam logic [CW-1:0] DEPTH = CW'(rset_pkg::TABLE_DEPTH);
   localparam logic [CW-1:0] ONE   = CW'(1);

   rset_pkg::entry_type    slot_ff [rset_pkg::TABLE_DEPTH];
   rset_pkg::entry_type    key_ff, key_in, rd, wr_data;
   rset_pkg::req_item_type req_ff;
   rset_pkg::rsp_item_type rsp_ff;

   logic [CW-1:0] k_ff, k_in, i_ff, i_in, j_ff, j_in, used_ff, used_in, pos_ff, pos_in;
   logic [CW-1:0] rd_idx, wr_idx, sel_idx, base, nav_idx, kidx, rem_idx;
   logic [31:0]   cid_ff, cid_in, cnt_ff, cnt_in, scan_key;
   logic          cval_ff, cval_in, alert_ff, alert_in, found_ff, found_in;
   logic          rsp_valid_ff, rsp_valid_in, wr_en, sel_en, move;
   logic [7:0]    cflags;

   // single read port
   assign rd = slot_ff[rd_idx[IW-1:0]];

   assign scan_key = (cmd == rset_pkg::CMD_SCAN_CUR) ? cid_ff : req_ff.entry_uuid;
   assign kidx     = (k_ff >= used_ff) ? '0 : k_ff;
   assign rem_idx  = (k_ff >= used_ff) ? used_ff - ONE : k_ff;
   assign base     = (pos_ff == '0) ? '0 : pos_ff - ONE;
   assign move     = (j_ff != '0) && rset_pkg::is_newer(key_ff, rd);

   // wrapping cursor step
   always_comb begin
      if (req_ff.req_type == rset_pkg::REQ_PREV) begin
         nav_idx = (base == '0) ? used_ff - ONE : base - ONE;
      end else begin
         nav_idx = (base + ONE >= used_ff) ? '0 : base + ONE;
      end
   end

   // read address per command
   always_comb begin
      case (cmd)
         rset_pkg::CMD_SCAN_REQ,
         rset_pkg::CMD_SCAN_CUR,
         rset_pkg::CMD_STORE_OLD: rd_idx = k_ff;
         rset_pkg::CMD_SORT_LOAD,
         rset_pkg::CMD_SHIFT:     rd_idx = i_ff;
         rset_pkg::CMD_SORT_CMP:  rd_idx = j_ff - ONE;
         rset_pkg::CMD_SEL_SCAN:  rd_idx = kidx;
         rset_pkg::CMD_SEL_REM:   rd_idx = rem_idx;
         rset_pkg::CMD_NAV:       rd_idx = nav_idx;
         rset_pkg::CMD_OUT:       rd_idx = pos_ff - ONE;
         default:                 rd_idx = '0;
      endcase
   end

   // status to the controller
   always_comb begin
      status.scan_end   = (k_ff >= used_ff);
      status.scan_hit   = (k_ff < used_ff) && (rd.id == scan_key);
      status.sort_done  = (i_ff >= used_ff);
      status.sort_move  = move;
      status.shift_done = (i_ff >= used_ff);
      status.rem_reloc  = (used_ff != '0) && (cid_ff != req_ff.entry_uuid);
      status.cur_valid  = cval_ff;
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // command execution
   always_comb begin
      k_in     = k_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      key_in   = key_ff;
      used_in  = used_ff;
      cnt_in   = cnt_ff;
      alert_in = alert_ff;
      found_in = found_ff;
      wr_en    = 1'b0;
      wr_idx   = '0;
      wr_data  = rd;
      sel_en   = 1'b0;
      sel_idx  = '0;
      pos_in   = pos_ff;
      cid_in   = cid_ff;
      cval_in  = cval_ff;
      cflags   = 8'd0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (cmd)
         rset_pkg::CMD_LOAD: begin
            k_in     = '0;
            alert_in = 1'b0;
            found_in = 1'b0;
         end
         rset_pkg::CMD_SCAN_REQ,
         rset_pkg::CMD_SCAN_CUR: begin
            if (status.scan_hit) begin
               i_in = k_ff + ONE;
               if (cmd == rset_pkg::CMD_SCAN_CUR) begin
                  pos_in = k_ff + ONE;
               end
            end else if (status.scan_end) begin
               if (cmd == rset_pkg::CMD_SCAN_CUR) begin
                  pos_in = '0;
               end
            end else begin
               k_in = k_ff + ONE;
            end
         end
         rset_pkg::CMD_STORE_OLD: begin
            found_in       = 1'b1;
            wr_en          = 1'b1;
            wr_idx         = k_ff;
            wr_data.id     = req_ff.entry_uuid;
            wr_data.flags  = req_ff.entry_flags;
            wr_data.tstamp = req_ff.entry_time;
            if (rd.seq == 32'd0) begin
               cnt_in      = cnt_ff + 32'd1;
               wr_data.seq = cnt_ff + 32'd1;
            end
            i_in = ONE;
         end
         rset_pkg::CMD_STORE_NEW: begin
            alert_in       = 1'b1;
            wr_en          = 1'b1;
            wr_idx         = (used_ff >= DEPTH) ? DEPTH - ONE : used_ff;
            wr_data.id     = req_ff.entry_uuid;
            wr_data.flags  = req_ff.entry_flags;
            wr_data.tstamp = req_ff.entry_time;
            wr_data.seq    = cnt_ff + 32'd1;
            cnt_in         = cnt_ff + 32'd1;
            if (used_ff < DEPTH) begin
               used_in = used_ff + ONE;
            end
            i_in = ONE;
         end
         rset_pkg::CMD_SORT_LOAD: begin
            if (i_ff < used_ff) begin
               key_in = rd;
               j_in   = i_ff;
            end else begin
               k_in = '0;
            end
         end
         rset_pkg::CMD_SORT_CMP: begin
            wr_en  = 1'b1;
            wr_idx = j_ff;
            if (move) begin
               wr_data = rd;
               j_in    = j_ff - ONE;
            end else begin
               wr_data = key_ff;
               i_in    = i_ff + ONE;
            end
         end
         rset_pkg::CMD_SEL_SCAN: begin
            sel_en  = 1'b1;
            sel_idx = kidx;
         end
         rset_pkg::CMD_SHIFT: begin
            found_in = 1'b1;
            wr_en    = 1'b1;
            if (i_ff < used_ff) begin
               wr_idx = i_ff - ONE;
               i_in   = i_ff + ONE;
            end else begin
               wr_idx  = used_ff - ONE;
               wr_data = '0;
               used_in = used_ff - ONE;
            end
         end
         rset_pkg::CMD_SEL_REM: begin
            if (used_ff == '0) begin
               sel_en = 1'b1;
            end else if (cid_ff == req_ff.entry_uuid) begin
               sel_en  = 1'b1;
               sel_idx = rem_idx;
            end else begin
               k_in = '0;
            end
         end
         rset_pkg::CMD_NAV: begin
            if (used_ff > ONE) begin
               sel_en  = 1'b1;
               sel_idx = nav_idx;
            end
         end
         rset_pkg::CMD_OUT: begin
            rsp_valid_in = 1'b1;
            if (pos_ff != '0 && pos_ff <= used_ff) begin
               cflags = rd.flags;
            end
         end
         default: begin
         end
      endcase
      // shared selection
      if (sel_en) begin
         if (used_ff == '0 || sel_idx >= used_ff) begin
            pos_in  = '0;
            cid_in  = 32'd0;
            cval_in = 1'b0;
         end else begin
            pos_in  = sel_idx + ONE;
            cid_in  = rd.id;
            cval_in = (rd.id != 32'd0);
         end
      end
   end

   // entry table, single write port
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < rset_pkg::TABLE_DEPTH; n++) begin
            slot_ff[n] <= '0;
         end
      end else if (wr_en) begin
         slot_ff[wr_idx[IW-1:0]] <= wr_data;
      end
   end

   // control and cursor registers
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         pos_ff       <= '0;
         cid_ff       <= 32'd0;
         cval_ff      <= 1'b0;
         cnt_ff       <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         pos_ff       <= pos_in;
         cid_ff       <= cid_in;
         cval_ff      <= cval_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      key_ff   <= key_in;
      alert_ff <= alert_in;
      found_ff <= found_in;
      if (cmd == rset_pkg::CMD_LOAD) begin
         req_ff <= req_data;
      end
      if (cmd == rset_pkg::CMD_OUT) begin
         rsp_ff.cur_uuid    <= cid_ff;
         rsp_ff.cur_flags   <= cflags;
         rsp_ff.cur_pos     <= pos_ff;
         rsp_ff.entry_count <= used_ff;
         rsp_ff.has_current <= cval_ff;
         rsp_ff.alert       <= alert_ff;
         rsp_ff.found       <= found_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= DEPTH) else $error("entry count beyond table depth");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd == rset_pkg::CMD_OUT) |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");
   a_cur_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.has_current) |-> (rsp_ff.cur_uuid != 32'd0))
      else $error("selection valid with zero id");
   a_alert_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.alert && rsp_ff.found))
      else $error("alert and found both set");
`endif

endmodule

// ----- rtl/recency_sorted_entry_table_unit.sv -----
// channel  dir  handshake             payload
// req_     in   req_valid/req_stall   rset_pkg::req_item_type
// rsp_     out  rsp_valid/rsp_stall   rset_pkg::rsp_item_type
//
// one item at a time, n being the entry count; an arrival takes load, lookup,
// store, insertion sort (up to n(n-1)/2 moves), then a relocate scan of a valid
// cursor or, for a new id, a select scan and select; a removal takes load,
// lookup, shift, select and a relocate scan if needed; prev and next load and step
// reset is synchronous and clears the table, count, cursor and counter
// a stalled result only holds the next item at its final step
module recency_sorted_entry_table_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rset_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rset_pkg::rsp_item_type rsp_data
);

   logic [rset_pkg::CMD_W-1:0] cmd;
   rset_pkg::status_type       status;

   // sequencer
   rset_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.req_type),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // table and cursor datapath
   rset_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
